// File: src/rsdz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdz_pkg
// Shared constants for the radial stick dead zone block.
// ----------------------------------------------------------------------------
package rsdz_pkg;

    // Field widths
    localparam int DATA_W      = 16;   // width of one sample field on the ports
    localparam int CFG_W       = 15;   // dead zone register width
    localparam int QUO_W       = 15;   // magnitude of one scaled output

    // Defaults
    localparam int SAMPLE_BITS_DEF = 16;

    // Q1.15 full scale and register reset value
    localparam logic [CFG_W-1:0] FULL_SCALE = 15'd32767;
    localparam logic [CFG_W-1:0] DZ_RESET   = 15'd7849;

endpackage

// File: src/rsdz_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdz_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees the quotient fits in Q_W bits (NUM_W = DEN_W + Q_W).
// ----------------------------------------------------------------------------
module rsdz_div #(
    parameter int DEN_W = 31,
    parameter int Q_W   = 15,
    parameter int NUM_W = DEN_W + Q_W
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo
);

    logic [NUM_W-1:0] r_rem [1:Q_W];
    logic [DEN_W-1:0] r_den [1:Q_W];
    logic [Q_W-1:0]   r_quo [1:Q_W];

    genvar j;
    generate
        for (j = 0; j < Q_W; j++) begin : g_stage
            logic [NUM_W-1:0] a_rem;
            logic [DEN_W-1:0] a_den;
            logic [Q_W-1:0]   a_quo;
            logic [NUM_W-1:0] w_sub;
            logic             w_ge;

            if (j == 0) begin : g_first
                assign a_rem = i_num;
                assign a_den = i_den;
                assign a_quo = '0;
            end else begin : g_next
                assign a_rem = r_rem[j];
                assign a_den = r_den[j];
                assign a_quo = r_quo[j];
            end

            // trial subtract of the divisor aligned to this quotient bit
            assign w_sub = NUM_W'({a_den, (Q_W)'(0)} >> (j + 1));
            assign w_ge  = (a_rem >= w_sub);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j+1] <= w_ge ? (a_rem - w_sub) : a_rem;
                    r_den[j+1] <= a_den;
                    r_quo[j+1] <= {a_quo[Q_W-2:0], w_ge};
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[Q_W];

endmodule

// File: src/radial_stick_dead_zone_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_stick_dead_zone_top
// Scaled radial dead zone for a signed joystick sample pair.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one transaction carries stick_x and stick_y.
//   Output stream (m_axis): one transaction per input, out_x and out_y in
//   Q1.15 on tdata, in_dead_zone on tuser.
//   Config channel (cfg): writes the dead zone radius; always ready. Write
//   it only while no sample is in flight.
// Throughput: one sample pair per cycle while the pipeline is not held by a stall.
// Pipeline: 3 front stages, one square root stage per result bit, 3 scale
//   stages, 15 divider stages, 1 output register.
// Reset: clears all valid bits and loads the radius with 7849.
// Stall: the whole pipeline holds while the output register is full and
//   not taken; s_axis_tready drops in the same cycle, so nothing is lost.
// ----------------------------------------------------------------------------
module radial_stick_dead_zone_top #(
    parameter int SAMPLE_BITS = rsdz_pkg::SAMPLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input samples
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [15:0] stick_x, [31:16] stick_y
    // results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [15:0] out_x, [31:16] out_y
    output logic [0:0]  o_m_axis_tuser,   // [0] in_dead_zone
    // dead zone radius
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [14:0] i_cfg_data
);

    localparam int N     = SAMPLE_BITS;
    localparam int SW    = 2 * N;
    localparam int CW    = (SW > 2 * rsdz_pkg::CFG_W) ? SW : 2 * rsdz_pkg::CFG_W;
    localparam int RW    = N + 2;
    localparam int QW    = rsdz_pkg::QUO_W;
    localparam int DW    = rsdz_pkg::CFG_W;
    localparam int DEN_W = N + DW;
    localparam int NUM_W = DEN_W + QW;

    typedef struct packed {
        logic          vld;
        logic          neg_x;
        logic          neg_y;
        logic [N-1:0]  ax;
        logic [N-1:0]  ay;
        logic [DW-1:0] dz;
        logic          in_dz;
    } t_side;

    typedef struct packed {
        logic vld;
        logic neg_x;
        logic neg_y;
        logic zero;
        logic in_dz;
    } t_tail;

    logic [DW-1:0] r_dz;
    logic          w_en;

    // global advance: output register empty or being taken
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_cfg_ready     = 1'b1;

    // dead zone radius register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz <= rsdz_pkg::DZ_RESET;
        end else if (i_cfg_valid) begin
            r_dz <= i_cfg_data;
        end
    end

    // stage 0: signs and absolute values
    logic signed [N-1:0] w_sx, w_sy;
    t_side               r_p0;

    assign w_sx = i_s_axis_tdata[N-1:0];
    assign w_sy = i_s_axis_tdata[rsdz_pkg::DATA_W +: N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0.vld <= 1'b0;
        end else if (w_en) begin
            r_p0.vld <= i_s_axis_tvalid;
        end
        if (w_en) begin
            r_p0.neg_x <= w_sx[N-1];
            r_p0.neg_y <= w_sy[N-1];
            r_p0.ax    <= w_sx[N-1] ? N'(-w_sx) : N'(w_sx);
            r_p0.ay    <= w_sy[N-1] ? N'(-w_sy) : N'(w_sy);
            r_p0.dz    <= r_dz;
            r_p0.in_dz <= 1'b0;
        end
    end

    // stage 1: squares
    t_side          r_p1;
    logic [SW-1:0]  r_sqx, r_sqy;
    logic [2*DW-1:0] r_dzsq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1.vld <= 1'b0;
        end else if (w_en) begin
            r_p1.vld <= r_p0.vld;
        end
        if (w_en) begin
            r_p1.neg_x <= r_p0.neg_x;
            r_p1.neg_y <= r_p0.neg_y;
            r_p1.ax    <= r_p0.ax;
            r_p1.ay    <= r_p0.ay;
            r_p1.dz    <= r_p0.dz;
            r_p1.in_dz <= 1'b0;
            r_sqx      <= SW'(r_p0.ax) * SW'(r_p0.ax);
            r_sqy      <= SW'(r_p0.ay) * SW'(r_p0.ay);
            r_dzsq     <= (2*DW)'(r_p0.dz) * (2*DW)'(r_p0.dz);
        end
    end

    // stage 2: squared length and dead zone test, seeds the square root
    logic [SW-1:0] w_s;
    t_side         r_sb   [0:N];
    logic [RW-1:0] r_rem  [0:N];
    logic [N-1:0]  r_root [0:N];
    logic [SW-1:0] r_s    [0:N];

    assign w_s = r_sqx + r_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb[0].vld <= 1'b0;
        end else if (w_en) begin
            r_sb[0].vld <= r_p1.vld;
        end
        if (w_en) begin
            r_sb[0].neg_x <= r_p1.neg_x;
            r_sb[0].neg_y <= r_p1.neg_y;
            r_sb[0].ax    <= r_p1.ax;
            r_sb[0].ay    <= r_p1.ay;
            r_sb[0].dz    <= r_p1.dz;
            r_sb[0].in_dz <= (CW'(w_s) <= CW'(r_dzsq));
            r_rem[0]      <= '0;
            r_root[0]     <= '0;
            r_s[0]        <= w_s;
        end
    end

    // square root: one result bit per stage
    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_sqrt
            logic [RW+1:0] w_rsh;
            logic [RW+1:0] w_trial;
            logic          w_ge;

            assign w_rsh   = {r_rem[k], r_s[k][SW-1:SW-2]};
            assign w_trial = (RW+2)'({r_root[k], 2'b01});
            assign w_ge    = (w_rsh >= w_trial);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sb[k+1].vld <= 1'b0;
                end else if (w_en) begin
                    r_sb[k+1].vld <= r_sb[k].vld;
                end
                if (w_en) begin
                    r_sb[k+1].neg_x <= r_sb[k].neg_x;
                    r_sb[k+1].neg_y <= r_sb[k].neg_y;
                    r_sb[k+1].ax    <= r_sb[k].ax;
                    r_sb[k+1].ay    <= r_sb[k].ay;
                    r_sb[k+1].dz    <= r_sb[k].dz;
                    r_sb[k+1].in_dz <= r_sb[k].in_dz;
                    r_rem[k+1]      <= w_ge ? RW'(w_rsh - w_trial) : RW'(w_rsh);
                    r_root[k+1]     <= {r_root[k][N-2:0], w_ge};
                    r_s[k+1]        <= {r_s[k][SW-3:0], 2'b00};
                end
            end
        end
    endgenerate

    // stage 3: clamp length, subtract radius, scale span
    logic [16:0]   w_mag_ext;
    logic [DW-1:0] w_clamped;
    t_side         r_p3;
    logic [N-1:0]  r_mag3;
    logic [DW-1:0] r_m3, r_span3;

    assign w_mag_ext = 17'(r_root[N]);
    assign w_clamped = (w_mag_ext > 17'(rsdz_pkg::FULL_SCALE)) ?
                       rsdz_pkg::FULL_SCALE : w_mag_ext[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3.vld <= 1'b0;
        end else if (w_en) begin
            r_p3.vld <= r_sb[N].vld;
        end
        if (w_en) begin
            r_p3.neg_x <= r_sb[N].neg_x;
            r_p3.neg_y <= r_sb[N].neg_y;
            r_p3.ax    <= r_sb[N].ax;
            r_p3.ay    <= r_sb[N].ay;
            r_p3.dz    <= r_sb[N].dz;
            r_p3.in_dz <= r_sb[N].in_dz;
            r_mag3     <= r_root[N];
            r_m3       <= (w_clamped >= r_sb[N].dz) ? (w_clamped - r_sb[N].dz) : '0;
            r_span3    <= rsdz_pkg::FULL_SCALE - r_sb[N].dz;
        end
    end

    // stage 4: axis times m, divisor mag times span
    t_tail            r_t4;
    logic [DEN_W-1:0] r_px4, r_py4, r_den4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t4.vld <= 1'b0;
        end else if (w_en) begin
            r_t4.vld <= r_p3.vld;
        end
        if (w_en) begin
            r_t4.neg_x <= r_p3.neg_x;
            r_t4.neg_y <= r_p3.neg_y;
            r_t4.zero  <= r_p3.in_dz || (r_m3 == '0);
            r_t4.in_dz <= r_p3.in_dz;
            r_px4      <= DEN_W'(r_p3.ax) * DEN_W'(r_m3);
            r_py4      <= DEN_W'(r_p3.ay) * DEN_W'(r_m3);
            r_den4     <= DEN_W'(r_mag3) * DEN_W'(r_span3);
        end
    end

    // stage 5: times full scale, as (p << 15) - p
    t_tail            r_t5;
    logic [NUM_W-1:0] r_nx5, r_ny5;
    logic [DEN_W-1:0] r_den5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t5.vld <= 1'b0;
        end else if (w_en) begin
            r_t5.vld <= r_t4.vld;
        end
        if (w_en) begin
            r_t5.neg_x <= r_t4.neg_x;
            r_t5.neg_y <= r_t4.neg_y;
            r_t5.zero  <= r_t4.zero;
            r_t5.in_dz <= r_t4.in_dz;
            r_nx5      <= {r_px4, QW'(0)} - NUM_W'(r_px4);
            r_ny5      <= {r_py4, QW'(0)} - NUM_W'(r_py4);
            r_den5     <= r_den4;
        end
    end

    // dividers, one per axis
    logic [QW-1:0] w_qx, w_qy;

    rsdz_div #(.DEN_W(DEN_W), .Q_W(QW), .NUM_W(NUM_W)) u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_nx5),
        .i_den (r_den5),
        .o_quo (w_qx)
    );

    rsdz_div #(.DEN_W(DEN_W), .Q_W(QW), .NUM_W(NUM_W)) u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_ny5),
        .i_den (r_den5),
        .o_quo (w_qy)
    );

    // sideband alongside the dividers
    t_tail r_tl [0:QW];

    always_comb r_tl[0] = r_t5;

    generate
        for (k = 0; k < QW; k++) begin : g_tail
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_tl[k+1].vld <= 1'b0;
                end else if (w_en) begin
                    r_tl[k+1].vld <= r_tl[k].vld;
                end
                if (w_en) begin
                    r_tl[k+1].neg_x <= r_tl[k].neg_x;
                    r_tl[k+1].neg_y <= r_tl[k].neg_y;
                    r_tl[k+1].zero  <= r_tl[k].zero;
                    r_tl[k+1].in_dz <= r_tl[k].in_dz;
                end
            end
        end
    endgenerate

    // output register: sign and zero forcing
    logic [15:0] w_ox, w_oy;
    logic        r_ovld;
    logic [31:0] r_odata;
    logic        r_ouser;

    assign w_ox = r_tl[QW].zero  ? 16'd0 :
                  r_tl[QW].neg_x ? 16'(-{1'b0, w_qx}) : 16'({1'b0, w_qx});
    assign w_oy = r_tl[QW].zero  ? 16'd0 :
                  r_tl[QW].neg_y ? 16'(-{1'b0, w_qy}) : 16'({1'b0, w_qy});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= r_tl[QW].vld;
        end
        if (w_en) begin
            r_odata <= {w_oy, w_ox};
            r_ouser <= r_tl[QW].in_dz;
        end
    end

    assign o_m_axis_tvalid   = r_ovld;
    assign o_m_axis_tdata    = r_odata;
    assign o_m_axis_tuser[0] = r_ouser;

endmodule
